// ----- rtl/core/lrs_pkg.sv -----
package lrs_pkg;

  // Operation codes carried by each request
  typedef enum logic [1:0] {
    OP_POLL     = 2'd0,
    OP_CONNECT  = 2'd1,
    OP_START_AP = 2'd2
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] REG_CHECK_INTERVAL    = 2'd0;
  localparam logic [1:0] REG_CONNECT_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_RECONNECT_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_MAX_RETRIES       = 2'd3;

  // Reset values of the configuration registers
  localparam logic [23:0] CHECK_INTERVAL_RST    = 24'd1000;
  localparam logic [23:0] CONNECT_TIMEOUT_RST   = 24'd10000;
  localparam logic [23:0] RECONNECT_TIMEOUT_RST = 24'd5000;
  localparam logic [7:0]  MAX_RETRIES_RST       = 8'd5;

  // Reported link state codes
  localparam logic [2:0] CODE_DISCONNECTED = 3'd0;
  localparam logic [2:0] CODE_CONNECTING   = 3'd1;
  localparam logic [2:0] CODE_CONNECTED    = 3'd2;
  localparam logic [2:0] CODE_RECONNECTING = 3'd3;
  localparam logic [2:0] CODE_AP_MODE      = 3'd4;
  localparam logic [2:0] CODE_ERROR        = 3'd5;

  // Supervisor state, one-hot
  typedef enum logic [5:0] {
    ST_DISCONNECTED = 6'b000001,
    ST_CONNECTING   = 6'b000010,
    ST_CONNECTED    = 6'b000100,
    ST_RECONNECTING = 6'b001000,
    ST_AP_MODE      = 6'b010000,
    ST_ERROR        = 6'b100000
  } state_t;

  localparam logic [7:0]  RETRY_MAX   = 8'hFF;
  localparam logic [15:0] SUCCESS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [23:0] check_interval_ms;
    logic [23:0] connect_timeout_ms;
    logic [23:0] reconnect_timeout_ms;
    logic [7:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] now_ms;
    logic        link_up;
  } item_t;

  typedef struct packed {
    logic [2:0]  link_state;
    logic [7:0]  retry_count;
    logic [15:0] success_count;
    logic [31:0] last_success_ms;
    logic        evaluated;
  } result_t;

  // State to reported code
  function automatic logic [2:0] state_code(input state_t st);
    logic [2:0] code;
    case (st)
      ST_CONNECTING:   code = CODE_CONNECTING;
      ST_CONNECTED:    code = CODE_CONNECTED;
      ST_RECONNECTING: code = CODE_RECONNECTING;
      ST_AP_MODE:      code = CODE_AP_MODE;
      ST_ERROR:        code = CODE_ERROR;
      default:         code = CODE_DISCONNECTED;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/lrs_cfg_regs.sv -----
module lrs_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  output lrs_pkg::cfg_t       cfg
);

  assign cfg_ready = 1'b1;

  // Register file, written whenever a write request arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_interval_ms    <= lrs_pkg::CHECK_INTERVAL_RST;
      cfg.connect_timeout_ms   <= lrs_pkg::CONNECT_TIMEOUT_RST;
      cfg.reconnect_timeout_ms <= lrs_pkg::RECONNECT_TIMEOUT_RST;
      cfg.max_retries          <= lrs_pkg::MAX_RETRIES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lrs_pkg::REG_CHECK_INTERVAL:    cfg.check_interval_ms    <= cfg_data;
        lrs_pkg::REG_CONNECT_TIMEOUT:   cfg.connect_timeout_ms   <= cfg_data;
        lrs_pkg::REG_RECONNECT_TIMEOUT: cfg.reconnect_timeout_ms <= cfg_data;
        lrs_pkg::REG_MAX_RETRIES:       cfg.max_retries          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/lrs_core.sv -----
module lrs_core (
  input  logic             clk,
  input  logic             rst,
  input  lrs_pkg::cfg_t    cfg,
  input  logic             advance,
  input  lrs_pkg::item_t   item,
  output lrs_pkg::result_t result
);

  lrs_pkg::state_t st, st_next;
  logic [31:0] entry_ms, entry_ms_next;
  logic [31:0] last_eval_ms, last_eval_ms_next;
  logic [7:0]  retries, retries_next;
  logic [15:0] successes, successes_next;
  logic [31:0] success_ms, success_ms_next;
  logic        evaluated;
  logic [31:0] elapsed;
  logic [31:0] since_eval;

  assign elapsed    = item.now_ms - entry_ms;
  assign since_eval = item.now_ms - last_eval_ms;

  // Next state for the request held in the input register
  always_comb begin
    st_next           = st;
    entry_ms_next     = entry_ms;
    last_eval_ms_next = last_eval_ms;
    retries_next      = retries;
    successes_next    = successes;
    success_ms_next   = success_ms;
    evaluated         = 1'b0;
    case (item.op)
      lrs_pkg::OP_POLL: begin
        if (since_eval >= {8'd0, cfg.check_interval_ms}) begin
          evaluated         = 1'b1;
          last_eval_ms_next = item.now_ms;
          case (st)
            lrs_pkg::ST_CONNECTING: begin
              if (elapsed > {8'd0, cfg.connect_timeout_ms}) begin
                st_next = lrs_pkg::ST_RECONNECTING;
              end else if (item.link_up) begin
                st_next         = lrs_pkg::ST_CONNECTED;
                success_ms_next = item.now_ms;
                if (successes != lrs_pkg::SUCCESS_MAX) successes_next = successes + 16'd1;
              end
            end
            lrs_pkg::ST_CONNECTED: begin
              if (!item.link_up) st_next = lrs_pkg::ST_RECONNECTING;
            end
            lrs_pkg::ST_RECONNECTING: begin
              if (elapsed > {8'd0, cfg.reconnect_timeout_ms}) begin
                if (retries >= cfg.max_retries) begin
                  st_next = lrs_pkg::ST_AP_MODE;
                end else begin
                  // another attempt: restart the attempt timer
                  if (retries != lrs_pkg::RETRY_MAX) retries_next = retries + 8'd1;
                  entry_ms_next = item.now_ms;
                end
              end else if (item.link_up) begin
                st_next         = lrs_pkg::ST_CONNECTED;
                success_ms_next = item.now_ms;
                retries_next    = 8'd0;
                if (successes != lrs_pkg::SUCCESS_MAX) successes_next = successes + 16'd1;
              end
            end
            lrs_pkg::ST_ERROR: begin
              if (retries <= cfg.max_retries) st_next = lrs_pkg::ST_RECONNECTING;
            end
            default: ;
          endcase
          if (st_next != st) entry_ms_next = item.now_ms;
        end
      end
      lrs_pkg::OP_CONNECT: begin
        // ignored while an attempt is already in flight; entry time kept
        if (st != lrs_pkg::ST_CONNECTING && st != lrs_pkg::ST_RECONNECTING) begin
          if (item.link_up) begin
            st_next      = lrs_pkg::ST_CONNECTED;
            retries_next = 8'd0;
          end else begin
            st_next = lrs_pkg::ST_ERROR;
            if (retries != lrs_pkg::RETRY_MAX) retries_next = retries + 8'd1;
          end
        end
      end
      lrs_pkg::OP_START_AP: begin
        st_next = lrs_pkg::ST_AP_MODE;
      end
      default: ;
    endcase
  end

  // State registers, updated as the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= lrs_pkg::ST_DISCONNECTED;
      entry_ms     <= 32'd0;
      last_eval_ms <= 32'd0;
      retries      <= 8'd0;
      successes    <= 16'd0;
      success_ms   <= 32'd0;
    end else if (advance) begin
      st           <= st_next;
      entry_ms     <= entry_ms_next;
      last_eval_ms <= last_eval_ms_next;
      retries      <= retries_next;
      successes    <= successes_next;
      success_ms   <= success_ms_next;
    end
  end

  assign result.link_state      = lrs_pkg::state_code(st_next);
  assign result.retry_count     = retries_next;
  assign result.success_count   = successes_next;
  assign result.last_success_ms = success_ms_next;
  assign result.evaluated       = evaluated;

endmodule

// ----- rtl/core/link_reconnect_supervisor_top.sv -----
// Link reconnect supervisor. Each request (poll, connect result or start
// access point, with a millisecond timestamp and the sampled link status)
// yields one result carrying the link state, retry count, success count,
// time of the last success and whether a poll ran a state evaluation.
// A request is captured in an input register and its result is loaded into
// the output register as the request advances, once the output register is
// free; one request per cycle is sustained while results are taken, limited
// only by the state update loop. While the result is stalled the input
// register holds one more request, then in_ready drops.
// Configuration writes are always taken and must only be issued while no
// request is in flight.
module link_reconnect_supervisor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] now_ms,
  input  logic        link_up,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  link_state,
  output logic [7:0]  retry_count,
  output logic [15:0] success_count,
  output logic [31:0] last_success_ms,
  output logic        evaluated
);

  lrs_pkg::cfg_t    cfg;
  lrs_pkg::item_t   s1_item;
  lrs_pkg::result_t result;
  lrs_pkg::result_t out_res;
  logic             s1_valid;
  logic             advance;

  lrs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: input stage moves on when the result register is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item.op      <= lrs_pkg::op_t'(operation);
      s1_item.now_ms  <= now_ms;
      s1_item.link_up <= link_up;
    end
  end

  lrs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (s1_item),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= result;
  end

  assign link_state      = out_res.link_state;
  assign retry_count     = out_res.retry_count;
  assign success_count   = out_res.success_count;
  assign last_success_ms = out_res.last_success_ms;
  assign evaluated       = out_res.evaluated;

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] now;
    logic        up;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = '0;
  logic [31:0] now_ms = '0;
  logic        link_up = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  link_state;
  logic [7:0]  retry_count;
  logic [15:0] success_count;
  logic [31:0] last_success_ms;
  logic        evaluated;

  link_reconnect_supervisor_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .now_ms(now_ms), .link_up(link_up),
    .out_valid(out_valid), .out_ready(out_ready),
    .link_state(link_state), .retry_count(retry_count), .success_count(success_count),
    .last_success_ms(last_success_ms), .evaluated(evaluated)
  );

  always #6 clk = ~clk;

  // Requests waiting to be driven, and results predicted for accepted requests
  request_t request_q[$];
  result_t  predicted_q[$];

  // Predictor copy of the configuration and the supervisor state
  logic [23:0] cfg_interval_ms;
  logic [23:0] cfg_connect_to_ms;
  logic [23:0] cfg_reconnect_to_ms;
  logic [7:0]  cfg_retry_limit;
  logic [2:0]  sup_state;
  logic [31:0] sup_entry_ms;
  logic [31:0] sup_last_eval_ms;
  logic [7:0]  sup_retries;
  logic [15:0] sup_successes;
  logic [31:0] sup_success_ms;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        req_took = 1'b0;
  int unsigned send_gap = 0;
  int unsigned sink_gap = 0;
  bit          calm = 1'b0;
  request_t    drive_req;

  // Stimulus generator state
  logic [31:0] wall_ms;
  logic        link_ok;

  // One request through the supervisor; returns the result it should give
  function automatic result_t step_supervisor(input logic [1:0] op, input logic [31:0] now,
                                              input logic up);
    result_t     r;
    logic [31:0] elapsed;
    logic [2:0]  nxt;
    logic        ran;
    ran = 1'b0;
    case (op)
      OP_POLL: begin
        if (now - sup_last_eval_ms >= {8'd0, cfg_interval_ms}) begin
          nxt = sup_state;
          elapsed = now - sup_entry_ms;
          case (sup_state)
            CODE_CONNECTING: begin
              if (elapsed > {8'd0, cfg_connect_to_ms}) begin
                nxt = CODE_RECONNECTING;
              end else if (up) begin
                nxt = CODE_CONNECTED;
                if (sup_successes != SUCCESS_MAX) sup_successes = sup_successes + 16'd1;
                sup_success_ms = now;
              end
            end
            CODE_CONNECTED: begin
              if (!up) nxt = CODE_RECONNECTING;
            end
            CODE_RECONNECTING: begin
              if (elapsed > {8'd0, cfg_reconnect_to_ms}) begin
                if (sup_retries >= cfg_retry_limit) begin
                  nxt = CODE_AP_MODE;
                end else begin
                  // another attempt: restart the attempt timer
                  if (sup_retries != RETRY_MAX) sup_retries = sup_retries + 8'd1;
                  sup_entry_ms = now;
                end
              end else if (up) begin
                nxt = CODE_CONNECTED;
                if (sup_successes != SUCCESS_MAX) sup_successes = sup_successes + 16'd1;
                sup_success_ms = now;
                sup_retries = '0;
              end
            end
            CODE_ERROR: begin
              if (sup_retries <= cfg_retry_limit) nxt = CODE_RECONNECTING;
            end
            default: ;
          endcase
          if (nxt != sup_state) begin
            sup_state = nxt;
            sup_entry_ms = now;
          end
          sup_last_eval_ms = now;
          ran = 1'b1;
        end
      end
      OP_CONNECT: begin
        // connect results are ignored while an attempt is running
        if (sup_state != CODE_CONNECTING && sup_state != CODE_RECONNECTING) begin
          if (up) begin
            sup_state = CODE_CONNECTED;
            sup_retries = '0;
          end else begin
            sup_state = CODE_ERROR;
            if (sup_retries != RETRY_MAX) sup_retries = sup_retries + 8'd1;
          end
        end
      end
      OP_START_AP: sup_state = CODE_AP_MODE;
      default: ;
    endcase
    r.link_state      = sup_state;
    r.retry_count     = sup_retries;
    r.success_count   = sup_successes;
    r.last_success_ms = sup_success_ms;
    r.evaluated       = ran;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (rst) begin
      req_took <= 1'b0;
      cfg_interval_ms = CHECK_INTERVAL_RST;
      cfg_connect_to_ms = CONNECT_TIMEOUT_RST;
      cfg_reconnect_to_ms = RECONNECT_TIMEOUT_RST;
      cfg_retry_limit = MAX_RETRIES_RST;
      sup_state = CODE_DISCONNECTED;
      sup_entry_ms = '0;
      sup_last_eval_ms = '0;
      sup_retries = '0;
      sup_successes = '0;
      sup_success_ms = '0;
    end else begin
      req_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          flag_mismatch("result with nothing outstanding");
        end else begin
          result_t want;
          want = predicted_q.pop_front();
          check_field("link_state", 32'(link_state), 32'(want.link_state));
          check_field("retry_count", 32'(retry_count), 32'(want.retry_count));
          check_field("success_count", 32'(success_count), 32'(want.success_count));
          check_field("last_success_ms", last_success_ms, want.last_success_ms);
          check_field("evaluated", 32'(evaluated), 32'(want.evaluated));
        end
      end
      if (in_valid && in_ready)
        predicted_q.push_back(step_supervisor(operation, now_ms, link_up));
    end
  end

  // Request driver with random idle bursts
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_took) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        drive_req = request_q.pop_front();
        operation <= drive_req.op;
        now_ms    <= drive_req.now;
        link_up   <= drive_req.up;
        in_valid  <= 1'b1;
        if (!calm && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink with random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      sink_gap <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_req(input logic [1:0] op, input logic [31:0] now, input logic up);
    request_t r;
    r.op = op;
    r.now = now;
    r.up = up;
    request_q.push_back(r);
  endtask

  task automatic tick(input int unsigned span);
    wall_ms = wall_ms + $urandom_range(0, span);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CHECK_INTERVAL:    cfg_interval_ms = val;
      REG_CONNECT_TIMEOUT:   cfg_connect_to_ms = val;
      REG_RECONNECT_TIMEOUT: cfg_reconnect_to_ms = val;
      default:               cfg_retry_limit = val[7:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [23:0] interval, input logic [23:0] conn_to,
                            input logic [23:0] reconn_to, input logic [23:0] limit);
    write_reg(REG_CHECK_INTERVAL, interval);
    write_reg(REG_CONNECT_TIMEOUT, conn_to);
    write_reg(REG_RECONNECT_TIMEOUT, reconn_to);
    write_reg(REG_MAX_RETRIES, limit);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic wait_idle();
    while (request_q.size() > 0 || in_valid || predicted_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic fail_storm(input int unsigned n, input int unsigned span);
    for (int unsigned k = 0; k < n; k++) begin
      tick(span);
      add_req(OP_CONNECT, wall_ms, 1'b0);
    end
  endtask

  // Mostly plausible link sessions with random timing, plus some noise
  task automatic add_random(input int unsigned count, input int unsigned span);
    int unsigned made;
    int unsigned kind;
    int unsigned n;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        // connect result followed by a run of polls with the link flapping
        tick(span);
        add_req(OP_CONNECT, wall_ms, $urandom_range(0, 3) != 0);
        n = $urandom_range(2, 12);
        for (int unsigned k = 0; k < n; k++) begin
          if ($urandom_range(0, 5) == 0) link_ok = ~link_ok;
          tick(span);
          add_req(OP_POLL, wall_ms, link_ok);
        end
        made += n + 1;
      end else if (kind < 7) begin
        // failed attempts in a row, now and then enough to saturate the retries
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(250, 270) : $urandom_range(1, 8);
        fail_storm(n, span);
        made += n;
      end else if (kind == 7) begin
        // fall back to access point, poll a little, then try the link again
        tick(span);
        add_req(OP_START_AP, wall_ms, 1'($urandom_range(0, 1)));
        n = $urandom_range(0, 3);
        for (int unsigned k = 0; k < n; k++) begin
          tick(span);
          add_req(OP_POLL, wall_ms, 1'($urandom_range(0, 1)));
        end
        tick(span);
        add_req(OP_CONNECT, wall_ms, 1'($urandom_range(0, 1)));
        made += n + 2;
      end else begin
        // noise: any code, any timestamp
        n = $urandom_range(1, 4);
        for (int unsigned k = 0; k < n; k++)
          add_req(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
        made += n;
      end
    end
  endtask

  initial begin
    wall_ms = '0;
    link_ok = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed walk through the states at the reset configuration
    add_req(OP_POLL, 32'd999, 1'b1);          // just short of the check interval
    add_req(OP_POLL, 32'd1000, 1'b1);         // exactly the interval, stays disconnected
    add_req(OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
    add_req(OP_START_AP, 32'd1100, 1'b0);
    add_req(OP_START_AP, 32'd1200, 1'b1);     // already in access point mode
    add_req(OP_POLL, 32'd2000, 1'b1);
    add_req(OP_CONNECT, 32'd2100, 1'b0);      // failed connect -> error
    add_req(OP_POLL, 32'd3000, 1'b0);         // error -> reconnecting
    add_req(OP_CONNECT, 32'd3100, 1'b1);      // ignored while reconnecting
    add_req(OP_POLL, 32'd8000, 1'b0);         // elapsed equals the timeout
    add_req(OP_POLL, 32'd9000, 1'b1);         // timed out, retry even though link up
    add_req(OP_POLL, 32'd10000, 1'b1);        // success
    add_req(OP_CONNECT, 32'd10100, 1'b1);
    add_req(OP_POLL, 32'd11000, 1'b0);        // link lost
    for (int unsigned k = 1; k <= 6; k++)     // retries run out -> access point
      add_req(OP_POLL, 32'd11000 + 32'd5001 * k, 1'b0);
    add_req(OP_CONNECT, 32'd50000, 1'b0);
    add_req(OP_CONNECT, 32'd50001, 1'b1);
    add_req(OP_POLL, 32'hFFFF_FFFF, 1'b1);
    wall_ms = 32'd60000;
    wait_idle();

    add_random(500, 1500);
    wait_idle();

    // short intervals and timeouts
    set_config(24'($urandom_range(0, 40)), 24'($urandom_range(0, 300)),
               24'($urandom_range(10, 200)), 24'($urandom_range(0, 4)));
    add_random(500, 60);
    wait_idle();

    // everything at zero
    set_config(24'd0, 24'd0, 24'd0, 24'd0);
    add_random(300, 8);
    wait_idle();

    // everything at its top, retry limit written with all data bits set
    set_config(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    fail_storm(260, 1000);
    for (int unsigned k = 0; k < 6; k++) begin
      tick(40_000_000);
      add_req(OP_POLL, wall_ms, 1'b0);
    end
    add_random(300, 24_000_000);
    wait_idle();

    // random settings with the clock about to wrap
    set_config(24'($urandom_range(0, 2000)), 24'($urandom), 24'($urandom_range(0, 5000)),
               24'($urandom_range(0, 255)));
    wall_ms = 32'hFFFF_8000;
    add_random(400, 3000);
    wait_idle();

    // no idling from here: back-to-back polls with the link flapping every request
    calm = 1'b1;
    set_config(24'd0, CONNECT_TIMEOUT_RST, 24'hFF_FFFF, 24'(MAX_RETRIES_RST));
    add_req(OP_START_AP, wall_ms, 1'b0);
    add_req(OP_CONNECT, wall_ms, 1'b1);
    for (int unsigned k = 0; k < 100; k++) begin
      wall_ms = wall_ms + 1;
      add_req(OP_POLL, wall_ms, 1'b0);
      wall_ms = wall_ms + 1;
      add_req(OP_POLL, wall_ms, 1'b1);
    end
    add_random(40, 20);
    wait_idle();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lrs_pkg.sv
rtl/core/lrs_cfg_regs.sv
rtl/core/lrs_core.sv
rtl/core/link_reconnect_supervisor_top.sv
test/tb_top.sv
